// ===== rtl/mp3df_pkg.sv =====
// Package for the MP3 frame deframer: command/status structs, status codes,
// tag constants and the bitrate, sample-rate and frame-length lookup functions.
// No dependencies; imported by every module of the block.
package mp3df_pkg;

    // Result status codes.
    localparam logic [2:0] ST_PAYLOAD = 3'd0;
    localparam logic [2:0] ST_END     = 3'd1;
    localparam logic [2:0] ST_NOTAG   = 3'd2;
    localparam logic [2:0] ST_VERSION = 3'd3;
    localparam logic [2:0] ST_LAYER   = 3'd4;
    localparam logic [2:0] ST_BITRATE = 3'd5;
    localparam logic [2:0] ST_RATE    = 3'd6;

    // MPEG version codes.
    localparam logic [1:0] VER_25       = 2'd0;
    localparam logic [1:0] VER_RESERVED = 2'd1;
    localparam logic [1:0] VER_2        = 2'd2;
    localparam logic [1:0] VER_1        = 2'd3;

    localparam logic [1:0] LAYER_III = 2'd1;

    // Tag signature characters.
    localparam logic [7:0] TAG_CHAR_I = 8'h49;
    localparam logic [7:0] TAG_CHAR_D = 8'h44;
    localparam logic [7:0] TAG_CHAR_3 = 8'h33;

    // Byte positions inside the tag header.
    localparam logic [3:0] TAG_IDX_FLAGS = 4'd5;
    localparam logic [3:0] TAG_IDX_SIZE  = 4'd6;
    localparam logic [3:0] TAG_IDX_LAST  = 4'd9;

    localparam int SKIP_W = 29;

    // Frame lengths at the 44.1 kHz family of rates, which are not a simple
    // multiple of the bitrate: floor(144000 * br / 44100) for MPEG-1 and
    // MPEG-2, floor(72000 * br / 11025) for MPEG-2.5, indexed by bitrate index.
    localparam logic [10:0] LEN44_V1 [16] = '{
        11'd0,   11'd104, 11'd130, 11'd156, 11'd182, 11'd208, 11'd261, 11'd313,
        11'd365, 11'd417, 11'd522, 11'd626, 11'd731, 11'd835, 11'd1044, 11'd0};
    localparam logic [10:0] LEN44_V2 [16] = '{
        11'd0,   11'd26,  11'd52,  11'd78,  11'd104, 11'd130, 11'd156, 11'd182,
        11'd208, 11'd261, 11'd313, 11'd365, 11'd417, 11'd470, 11'd522, 11'd0};
    localparam logic [10:0] LEN44_V25 [16] = '{
        11'd0,   11'd52,  11'd104, 11'd156, 11'd208, 11'd261, 11'd313, 11'd365,
        11'd417, 11'd522, 11'd626, 11'd731, 11'd835, 11'd940, 11'd1044, 11'd0};

    typedef struct packed {
        logic       flags_ld;
        logic       tag_shift;
        logic       ext_shift;
        logic       skip_ld_tag;
        logic       skip_ld_ext;
        logic       skip_dec;
        logic       hdr0_ld;
        logic       hdr1_ld;
        logic       hdr2_ld;
        logic       hdr3_ld;
        logic       pay_emit;
        logic       st_emit;
        logic [2:0] st_code;
    } t_cmd;

    typedef struct packed {
        logic is_char_i;
        logic is_char_d;
        logic is_char_3;
        logic flag_ext;
        logic tag_skip_zero;
        logic ext_skip_zero;
        logic skip_last;
        logic sync_ok;
        logic ver_bad;
        logic layer_bad;
        logic br_bad;
        logic sr_bad;
        logic pay_last;
    } t_sts;

    // Bitrate in kbit/s; zero marks a free or forbidden index.
    function automatic logic [8:0] f_bitrate(input logic [1:0] ver, input logic [3:0] bi);
        logic [8:0] br;
        br = 9'd0;
        if (ver == VER_1) begin
            case (bi)
                4'd1:    br = 9'd32;
                4'd2:    br = 9'd40;
                4'd3:    br = 9'd48;
                4'd4:    br = 9'd56;
                4'd5:    br = 9'd64;
                4'd6:    br = 9'd80;
                4'd7:    br = 9'd96;
                4'd8:    br = 9'd112;
                4'd9:    br = 9'd128;
                4'd10:   br = 9'd160;
                4'd11:   br = 9'd192;
                4'd12:   br = 9'd224;
                4'd13:   br = 9'd256;
                4'd14:   br = 9'd320;
                default: br = 9'd0;
            endcase
        end else begin
            case (bi)
                4'd1:    br = 9'd8;
                4'd2:    br = 9'd16;
                4'd3:    br = 9'd24;
                4'd4:    br = 9'd32;
                4'd5:    br = 9'd40;
                4'd6:    br = 9'd48;
                4'd7:    br = 9'd56;
                4'd8:    br = 9'd64;
                4'd9:    br = 9'd80;
                4'd10:   br = 9'd96;
                4'd11:   br = 9'd112;
                4'd12:   br = 9'd128;
                4'd13:   br = 9'd144;
                4'd14:   br = 9'd160;
                default: br = 9'd0;
            endcase
        end
        return br;
    endfunction

    // Sample rate in hertz; zero marks the reserved index.
    function automatic logic [15:0] f_srate(input logic [1:0] ver, input logic [1:0] si);
        logic [15:0] sr;
        sr = 16'd0;
        case (si)
            2'd0: sr = (ver == VER_1) ? 16'd44100 : ((ver == VER_2) ? 16'd22050 : 16'd11025);
            2'd1: sr = (ver == VER_1) ? 16'd48000 : ((ver == VER_2) ? 16'd24000 : 16'd12000);
            2'd2: sr = (ver == VER_1) ? 16'd32000 : ((ver == VER_2) ? 16'd16000 : 16'd8000);
            default: sr = 16'd0;
        endcase
        return sr;
    endfunction

    // Frame length without padding: floor(coef * br / sr). Outside the
    // 44.1 kHz family the ratio coef / sr is 3, 4.5, 6 or 9.
    function automatic logic [10:0] f_frame_base(input logic [1:0] ver,
                                                 input logic [3:0] bi,
                                                 input logic [1:0] si);
        logic [11:0] br12;
        logic [11:0] x3;
        logic [11:0] x9;
        logic [11:0] len;
        br12 = {3'd0, f_bitrate(ver, bi)};
        x3   = br12 + {br12[10:0], 1'b0};
        x9   = x3 + {x3[10:0], 1'b0};
        len  = 12'd0;
        case (si)
            2'd0: begin
                if (ver == VER_1) begin
                    len = {1'b0, LEN44_V1[bi]};
                end else if (ver == VER_2) begin
                    len = {1'b0, LEN44_V2[bi]};
                end else begin
                    len = {1'b0, LEN44_V25[bi]};
                end
            end
            2'd1: len = (ver == VER_25) ? {x3[10:0], 1'b0} : x3;
            2'd2: len = (ver == VER_25) ? x9 : {1'b0, x9[11:1]};
            default: len = 12'd0;
        endcase
        return len[10:0];
    endfunction

endpackage

// ===== rtl/mp3_frame_deframer_top.sv =====
// Top level of the MP3 frame deframer: joins the phase controller and the
// datapath. Depends on mp3df_pkg, mp3df_ctrl and mp3df_datapath.
//
//   Channel  | Direction | Handshake               | Item
//   ---------+-----------+-------------------------+------------------------------
//   in       | input     | i_in_valid / o_in_stall | one file byte
//   out      | output    | o_out_valid / i_out_stall | payload byte or status word
//
// The controller acts on each byte in the cycle it is accepted, so a byte may
// enter in every cycle while the input does not stall.
// Results go through a single output register; input stalls only while that
// register is full and the output side stalls.
// Synchronous active-low reset returns to reading the tag header.
// After an end or error status, bytes are still taken and give no result.
module mp3_frame_deframer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_payload_byte,
    output logic        o_first_of_frame,
    output logic        o_last_of_frame,
    output logic [1:0]  o_mpeg_version,
    output logic [8:0]  o_bitrate_kbps,
    output logic [15:0] o_sample_rate_hz,
    output logic [1:0]  o_channel_mode,
    output logic [1:0]  o_joint_stereo_ext,
    output logic [10:0] o_frame_length_bytes,
    output logic [2:0]  o_status
);
    import mp3df_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic in_stall;
    logic accept;

    // An item is accepted when valid and not stalled.
    assign accept     = i_in_valid && !in_stall;
    assign o_in_stall = in_stall;

    mp3df_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_sts    (sts),
        .o_cmd    (cmd)
    );

    mp3df_datapath u_datapath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_data_byte          (i_data_byte),
        .i_cmd                (cmd),
        .o_sts                (sts),
        .i_out_stall          (i_out_stall),
        .o_in_stall           (in_stall),
        .o_out_valid          (o_out_valid),
        .o_payload_byte       (o_payload_byte),
        .o_first_of_frame     (o_first_of_frame),
        .o_last_of_frame      (o_last_of_frame),
        .o_mpeg_version       (o_mpeg_version),
        .o_bitrate_kbps       (o_bitrate_kbps),
        .o_sample_rate_hz     (o_sample_rate_hz),
        .o_channel_mode       (o_channel_mode),
        .o_joint_stereo_ext   (o_joint_stereo_ext),
        .o_frame_length_bytes (o_frame_length_bytes),
        .o_status             (o_status)
    );

endmodule

// ===== rtl/mp3df_ctrl.sv =====
// Controller of the MP3 frame deframer: walks tag, extended header, skip,
// frame header and payload phases, and issues commands to the datapath.
// Depends on mp3df_pkg.
module mp3df_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  mp3df_pkg::t_sts   i_sts,
    output mp3df_pkg::t_cmd   o_cmd
);
    import mp3df_pkg::*;

    typedef enum logic [2:0] {
        S_TAG,
        S_EXT,
        S_SKIP,
        S_HDR,
        S_PAY,
        S_DONE
    } t_state;

    t_state     r_state, n_state;
    logic [3:0] r_hidx, n_hidx;
    t_cmd       cmd;

    // Next state, byte index and commands for the item being accepted.
    always_comb begin
        n_state = r_state;
        n_hidx  = r_hidx;
        cmd     = '0;
        if (i_accept) begin
            unique case (r_state)
                S_TAG: begin
                    if ((r_hidx == 4'd0 && !i_sts.is_char_i) ||
                        (r_hidx == 4'd1 && !i_sts.is_char_d) ||
                        (r_hidx == 4'd2 && !i_sts.is_char_3)) begin
                        cmd.st_emit = 1'b1;
                        cmd.st_code = ST_NOTAG;
                        n_state     = S_DONE;
                    end else begin
                        cmd.flags_ld  = (r_hidx == TAG_IDX_FLAGS);
                        cmd.tag_shift = (r_hidx >= TAG_IDX_SIZE);
                        if (r_hidx == TAG_IDX_LAST) begin
                            n_hidx = 4'd0;
                            if (i_sts.flag_ext) begin
                                n_state = S_EXT;
                            end else begin
                                cmd.skip_ld_tag = 1'b1;
                                n_state = i_sts.tag_skip_zero ? S_HDR : S_SKIP;
                            end
                        end else begin
                            n_hidx = r_hidx + 4'd1;
                        end
                    end
                end
                S_EXT: begin
                    cmd.ext_shift = 1'b1;
                    if (r_hidx == 4'd3) begin
                        cmd.skip_ld_ext = 1'b1;
                        n_hidx  = 4'd0;
                        n_state = i_sts.ext_skip_zero ? S_HDR : S_SKIP;
                    end else begin
                        n_hidx = r_hidx + 4'd1;
                    end
                end
                S_SKIP: begin
                    cmd.skip_dec = 1'b1;
                    if (i_sts.skip_last) begin
                        n_hidx  = 4'd0;
                        n_state = S_HDR;
                    end
                end
                S_HDR: begin
                    unique case (r_hidx[1:0])
                        2'd0: begin
                            cmd.hdr0_ld = 1'b1;
                            n_hidx = 4'd1;
                        end
                        2'd1: begin
                            if (!i_sts.sync_ok) begin
                                cmd.st_emit = 1'b1;
                                cmd.st_code = ST_END;
                                n_state     = S_DONE;
                            end else if (i_sts.ver_bad) begin
                                cmd.st_emit = 1'b1;
                                cmd.st_code = ST_VERSION;
                                n_state     = S_DONE;
                            end else if (i_sts.layer_bad) begin
                                cmd.st_emit = 1'b1;
                                cmd.st_code = ST_LAYER;
                                n_state     = S_DONE;
                            end else begin
                                cmd.hdr1_ld = 1'b1;
                                n_hidx = 4'd2;
                            end
                        end
                        2'd2: begin
                            if (i_sts.br_bad) begin
                                cmd.st_emit = 1'b1;
                                cmd.st_code = ST_BITRATE;
                                n_state     = S_DONE;
                            end else if (i_sts.sr_bad) begin
                                cmd.st_emit = 1'b1;
                                cmd.st_code = ST_RATE;
                                n_state     = S_DONE;
                            end else begin
                                cmd.hdr2_ld = 1'b1;
                                n_hidx = 4'd3;
                            end
                        end
                        default: begin
                            cmd.hdr3_ld = 1'b1;
                            n_hidx  = 4'd0;
                            n_state = S_PAY;
                        end
                    endcase
                end
                S_PAY: begin
                    cmd.pay_emit = 1'b1;
                    if (i_sts.pay_last) begin
                        n_hidx  = 4'd0;
                        n_state = S_HDR;
                    end
                end
                S_DONE: begin
                    n_state = S_DONE;
                end
                default: begin
                    n_state = S_DONE;
                end
            endcase
        end
    end

    // State and byte index registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_TAG;
            r_hidx  <= 4'd0;
        end else begin
            r_state <= n_state;
            r_hidx  <= n_hidx;
        end
    end

    assign o_cmd = cmd;

endmodule

// ===== rtl/mp3df_datapath.sv =====
// Datapath of the MP3 frame deframer: tag size accumulators, skip counter,
// frame header registers, payload counter and the output item register.
// Depends on mp3df_pkg.
module mp3df_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [7:0]        i_data_byte,
    input  mp3df_pkg::t_cmd   i_cmd,
    output mp3df_pkg::t_sts   o_sts,
    input  logic              i_out_stall,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output logic [7:0]        o_payload_byte,
    output logic              o_first_of_frame,
    output logic              o_last_of_frame,
    output logic [1:0]        o_mpeg_version,
    output logic [8:0]        o_bitrate_kbps,
    output logic [15:0]       o_sample_rate_hz,
    output logic [1:0]        o_channel_mode,
    output logic [1:0]        o_joint_stereo_ext,
    output logic [10:0]       o_frame_length_bytes,
    output logic [2:0]        o_status
);
    import mp3df_pkg::*;

    // Tag and skip registers.
    logic [27:0]       r_tag_size, n_tag_size;
    logic [27:0]       r_ext_size, n_ext_size;
    logic [7:0]        r_tag_flags;
    logic [SKIP_W-1:0] r_skip;
    logic [SKIP_W-1:0] ext_total;
    logic [SKIP_W-1:0] ext_skip;

    // Frame header registers.
    logic [7:0]  r_hdr0;
    logic [1:0]  r_version;
    logic [8:0]  r_bitrate;
    logic [15:0] r_srate;
    logic [3:0]  r_chan_bits;
    logic [10:0] r_frame_len;
    logic [10:0] r_pay_left;
    logic [10:0] pay_total;

    // Header byte decode.
    logic [8:0]  dec_br;
    logic [15:0] dec_sr;
    logic [10:0] dec_len;

    // Output item register.
    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_o_byte;
    logic        r_o_first, r_o_last;
    logic [1:0]  r_o_ver;
    logic [8:0]  r_o_br;
    logic [15:0] r_o_sr;
    logic [1:0]  r_o_mode, r_o_ext;
    logic [10:0] r_o_len;
    logic [2:0]  r_o_status;
    logic        emit;

    // Syncsafe accumulation: seven bits per byte.
    assign n_tag_size = {r_tag_size[20:0], i_data_byte[6:0]};
    assign n_ext_size = {r_ext_size[20:0], i_data_byte[6:0]};
    assign ext_total  = {1'b0, r_tag_size} + {1'b0, n_ext_size};
    assign ext_skip   = (ext_total >= SKIP_W'(4)) ? ext_total - SKIP_W'(4) : '0;

    assign dec_br    = f_bitrate(r_version, i_data_byte[7:4]);
    assign dec_sr    = f_srate(r_version, i_data_byte[3:2]);
    assign dec_len   = f_frame_base(r_version, i_data_byte[7:4], i_data_byte[3:2])
                       + {10'd0, i_data_byte[1]};
    assign pay_total = r_frame_len - 11'd4;

    // Status toward the controller.
    always_comb begin
        o_sts.is_char_i     = (i_data_byte == TAG_CHAR_I);
        o_sts.is_char_d     = (i_data_byte == TAG_CHAR_D);
        o_sts.is_char_3     = (i_data_byte == TAG_CHAR_3);
        o_sts.flag_ext      = r_tag_flags[0];
        o_sts.tag_skip_zero = (n_tag_size == 28'd0);
        o_sts.ext_skip_zero = (ext_skip == '0);
        o_sts.skip_last     = (r_skip == SKIP_W'(1));
        o_sts.sync_ok       = (r_hdr0 == 8'hFF) && (i_data_byte[7:5] == 3'b111);
        o_sts.ver_bad       = (i_data_byte[4:3] == VER_RESERVED);
        o_sts.layer_bad     = (i_data_byte[2:1] != LAYER_III);
        o_sts.br_bad        = (dec_br == 9'd0);
        o_sts.sr_bad        = (dec_sr == 16'd0);
        o_sts.pay_last      = (r_pay_left == 11'd1);
    end

    // Tag, skip and header registers; loaded only on command.
    always_ff @(posedge i_clk) begin
        if (i_cmd.flags_ld) begin
            r_tag_flags <= i_data_byte;
        end
        if (i_cmd.tag_shift) begin
            r_tag_size <= n_tag_size;
        end
        if (i_cmd.ext_shift) begin
            r_ext_size <= n_ext_size;
        end
        if (i_cmd.skip_ld_tag) begin
            r_skip <= {1'b0, n_tag_size};
        end else if (i_cmd.skip_ld_ext) begin
            r_skip <= ext_skip;
        end else if (i_cmd.skip_dec) begin
            r_skip <= r_skip - SKIP_W'(1);
        end
        if (i_cmd.hdr0_ld) begin
            r_hdr0 <= i_data_byte;
        end
        if (i_cmd.hdr1_ld) begin
            r_version <= i_data_byte[4:3];
        end
        if (i_cmd.hdr2_ld) begin
            r_bitrate   <= dec_br;
            r_srate     <= dec_sr;
            r_frame_len <= dec_len;
        end
        if (i_cmd.hdr3_ld) begin
            r_chan_bits <= i_data_byte[7:4];
            r_pay_left  <= pay_total;
        end else if (i_cmd.pay_emit) begin
            r_pay_left <= r_pay_left - 11'd1;
        end
    end

    // Output item register: a new item may enter while the held one is taken.
    assign emit        = i_cmd.pay_emit || i_cmd.st_emit;
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign n_out_valid = emit ? 1'b1 : (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pay_emit) begin
            r_o_byte   <= i_data_byte;
            r_o_first  <= (r_pay_left == pay_total);
            r_o_last   <= (r_pay_left == 11'd1);
            r_o_ver    <= r_version;
            r_o_br     <= r_bitrate;
            r_o_sr     <= r_srate;
            r_o_mode   <= r_chan_bits[3:2];
            r_o_ext    <= r_chan_bits[1:0];
            r_o_len    <= r_frame_len;
            r_o_status <= ST_PAYLOAD;
        end else if (i_cmd.st_emit) begin
            r_o_byte   <= 8'd0;
            r_o_first  <= 1'b0;
            r_o_last   <= 1'b0;
            r_o_ver    <= 2'd0;
            r_o_br     <= 9'd0;
            r_o_sr     <= 16'd0;
            r_o_mode   <= 2'd0;
            r_o_ext    <= 2'd0;
            r_o_len    <= 11'd0;
            r_o_status <= i_cmd.st_code;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_payload_byte       = r_o_byte;
    assign o_first_of_frame     = r_o_first;
    assign o_last_of_frame      = r_o_last;
    assign o_mpeg_version       = r_o_ver;
    assign o_bitrate_kbps       = r_o_br;
    assign o_sample_rate_hz     = r_o_sr;
    assign o_channel_mode       = r_o_mode;
    assign o_joint_stereo_ext   = r_o_ext;
    assign o_frame_length_bytes = r_o_len;
    assign o_status             = r_o_status;

endmodule
